>>> hdl/great_circle_distance_core_macros.svh
// assertion macros for the great-circle distance core
`ifndef GREAT_CIRCLE_DISTANCE_CORE_MACROS_SVH
`define GREAT_CIRCLE_DISTANCE_CORE_MACROS_SVH

// plain property check on clk, off during reset
`define GCD_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// antecedent now needs cond to have held at the earlier sample that n selects in $past
`define GCD_ASSERT_PAST(lbl, ante, cond, n, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> $past(cond, n)) \
    else $error(msg);

`endif

>>> hdl/gcd_pkg.sv
// shared types, constants and tables for the great-circle distance core
`default_nettype none
package gcd_pkg;

  localparam int CORDIC_STAGES = 30;
  localparam int ATAN_DEPTH    = 40;
  localparam int ANG_W         = 38;
  localparam int XY_W          = 36;
  localparam int SQ_W          = 61;
  localparam int SQ_STEPS      = 31;
  localparam int NUM_W         = 62;
  localparam int DIV_W         = 32;
  localparam int DIV_STEPS     = 4;

  localparam logic signed [ANG_W-1:0] PI_Q32     = 38'sh3243F6A89;
  localparam logic signed [ANG_W-1:0] HALFPI_Q32 = 38'sh1921FB544;
  localparam logic signed [ANG_W-1:0] TWOPI_Q32  = 38'sh6487ED512;
  localparam logic signed [XY_W-1:0]  KINV_Q32   = 36'sh09B74EDA8;
  localparam logic [29:0]             PI_Q28     = 30'h3243F6A9;
  localparam logic [NUM_W-1:0]        PI_Q28_HALF = 62'h1921FB54;
  localparam logic [SQ_W-1:0]         ONE_Q60    = 61'h1000000000000000;
  // just below 2^61 / pi_q28, so the quotient estimate never overshoots
  localparam logic [31:0]             DEG_RECIP  = 32'd2734261099;

  // atan(2^-i) in q.32
  localparam logic [31:0] ATAN_TAB [ATAN_DEPTH] = '{
    32'hC90FDAA2, 32'h76B19C16, 32'h3EB6EBF2, 32'h1FD5BA9B,
    32'h0FFAADDC, 32'h07FF556F, 32'h03FFEAAB, 32'h01FFFD55,
    32'h00FFFFAB, 32'h007FFFF5, 32'h003FFFFF, 32'h00200000,
    32'h00100000, 32'h00080000, 32'h00040000, 32'h00020000,
    32'h00010000, 32'h00008000, 32'h00004000, 32'h00002000,
    32'h00001000, 32'h00000800, 32'h00000400, 32'h00000200,
    32'h00000100, 32'h00000080, 32'h00000040, 32'h00000020,
    32'h00000010, 32'h00000008, 32'h00000004, 32'h00000002,
    32'h00000001, 32'h00000001, 32'h00000000, 32'h00000000,
    32'h00000000, 32'h00000000, 32'h00000000, 32'h00000000
  };

  typedef struct packed {
    logic signed [XY_W-1:0]  x;
    logic signed [XY_W-1:0]  y;
    logic signed [ANG_W-1:0] z;
    logic                    neg;
  } rot_lane_t;

  typedef struct packed {
    logic                 vld;
    rot_lane_t [2:0]      lane;
  } rot_beat_t;

  typedef struct packed {
    logic                 vld;
    logic [SQ_W-1:0]      v;
    logic [SQ_W-1:0]      r;
    logic signed [31:0]   c;
  } sq_beat_t;

  typedef struct packed {
    logic                    vld;
    logic signed [XY_W-1:0]  x;
    logic signed [XY_W-1:0]  y;
    logic signed [ANG_W-1:0] z;
  } vec_beat_t;

  typedef struct packed {
    logic              vld;
    logic [DIV_W-1:0]  rem;
    logic [31:0]       q;
    logic [31:0]       rad;
  } div_beat_t;

endpackage
`default_nettype wire

>>> hdl/gcd_rot_cell.sv
// one cordic rotation stage for three angle lanes
`default_nettype none
module gcd_rot_cell import gcd_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic [5:0] step,
  input  rot_beat_t d_i,
  output rot_beat_t d_o
);

  rot_beat_t d_r;
  rot_lane_t [2:0] lane_nxt;
  logic signed [ANG_W-1:0] ang;

  always_comb begin
    ang = signed'({{(ANG_W-32){1'b0}}, ATAN_TAB[step]});
    for (int l = 0; l < 3; l++) begin
      lane_nxt[l].neg = d_i.lane[l].neg;
      if (d_i.lane[l].z >= 0) begin
        lane_nxt[l].x = d_i.lane[l].x - (d_i.lane[l].y >>> step);
        lane_nxt[l].y = d_i.lane[l].y + (d_i.lane[l].x >>> step);
        lane_nxt[l].z = d_i.lane[l].z - ang;
      end else begin
        lane_nxt[l].x = d_i.lane[l].x + (d_i.lane[l].y >>> step);
        lane_nxt[l].y = d_i.lane[l].y - (d_i.lane[l].x >>> step);
        lane_nxt[l].z = d_i.lane[l].z + ang;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      d_r.vld <= 1'b0;
    end else begin
      d_r.vld <= d_i.vld;
    end
  end

  always_ff @(posedge clk) begin
    d_r.lane <= lane_nxt;
  end

  assign d_o = d_r;

endmodule
`default_nettype wire

>>> hdl/gcd_sqrt_cell.sv
// one result bit of the pipelined integer square root
`default_nettype none
module gcd_sqrt_cell import gcd_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic [4:0] step,
  input  sq_beat_t  d_i,
  output sq_beat_t  d_o
);

  sq_beat_t d_r;
  logic [SQ_W-1:0] bitv, trial, v_nxt, r_nxt;

  always_comb begin
    bitv  = SQ_W'(1) << {step, 1'b0};
    trial = d_i.r + bitv;
    if (d_i.v >= trial) begin
      v_nxt = d_i.v - trial;
      r_nxt = (d_i.r >> 1) + bitv;
    end else begin
      v_nxt = d_i.v;
      r_nxt = d_i.r >> 1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      d_r.vld <= 1'b0;
    end else begin
      d_r.vld <= d_i.vld;
    end
  end

  always_ff @(posedge clk) begin
    d_r.v <= v_nxt;
    d_r.r <= r_nxt;
    d_r.c <= d_i.c;
  end

  assign d_o = d_r;

endmodule
`default_nettype wire

>>> hdl/gcd_vec_cell.sv
// one cordic vectoring stage for the arc cosine
`default_nettype none
module gcd_vec_cell import gcd_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic [5:0] step,
  input  vec_beat_t d_i,
  output vec_beat_t d_o
);

  vec_beat_t d_r;
  logic signed [XY_W-1:0]  x_nxt, y_nxt;
  logic signed [ANG_W-1:0] z_nxt, ang;

  always_comb begin
    ang = signed'({{(ANG_W-32){1'b0}}, ATAN_TAB[step]});
    if (d_i.y > 0) begin
      x_nxt = d_i.x + (d_i.y >>> step);
      y_nxt = d_i.y - (d_i.x >>> step);
      z_nxt = d_i.z + ang;
    end else begin
      x_nxt = d_i.x - (d_i.y >>> step);
      y_nxt = d_i.y + (d_i.x >>> step);
      z_nxt = d_i.z - ang;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      d_r.vld <= 1'b0;
    end else begin
      d_r.vld <= d_i.vld;
    end
  end

  always_ff @(posedge clk) begin
    d_r.x <= x_nxt;
    d_r.y <= y_nxt;
    d_r.z <= z_nxt;
  end

  assign d_o = d_r;

endmodule
`default_nettype wire

>>> hdl/gcd_div_cell.sv
// one correction step of the divide by pi for the degree scaling
`default_nettype none
module gcd_div_cell import gcd_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  div_beat_t d_i,
  output div_beat_t d_o
);

  div_beat_t d_r;
  logic [DIV_W-1:0] rem_nxt;
  logic [31:0]      q_nxt;

  always_comb begin
    if (d_i.rem >= DIV_W'(PI_Q28)) begin
      rem_nxt = d_i.rem - DIV_W'(PI_Q28);
      q_nxt   = d_i.q + 32'd1;
    end else begin
      rem_nxt = d_i.rem;
      q_nxt   = d_i.q;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      d_r.vld <= 1'b0;
    end else begin
      d_r.vld <= d_i.vld;
    end
  end

  always_ff @(posedge clk) begin
    d_r.rem <= rem_nxt;
    d_r.q   <= q_nxt;
    d_r.rad <= d_i.rad;
  end

  assign d_o = d_r;

endmodule
`default_nettype wire

>>> hdl/great_circle_distance_core.sv
// great-circle distance core: law of cosines on cordic sin/cos, square root and acos
//
//   channel | ports                                   | beat taken when
//   --------+-----------------------------------------+-----------------------
//   input   | start, busy, in_alt_a/az_a/alt_b/az_b   | start high, busy low
//   result  | out_valid, out_distance                 | every cycle out_valid high
//   config  | cfg_we, cfg_wdata                       | cfg_we high
//
// fully pipelined: one direction pair per cycle, busy is always low
// the pipeline is made of the two cordic rows,
// the 31-step square root row and the reciprocal divide with its four correction cells
// sync active-low reset clears the valid bits and the degree mode register
// the result is shown for one cycle only; the receiver cannot stall it
`default_nettype none
`include "great_circle_distance_core_macros.svh"
module great_circle_distance_core import gcd_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic signed [31:0] in_alt_a,
  input  logic signed [31:0] in_az_a,
  input  logic signed [31:0] in_alt_b,
  input  logic signed [31:0] in_az_b,
  input  logic               cfg_we,
  input  logic               cfg_wdata,
  output logic               out_valid,
  output logic [31:0]        out_distance
);

  localparam int LAT = 2 * CORDIC_STAGES + 54;

  // wrap once by two pi into [-pi, pi]
  function automatic logic signed [ANG_W-1:0] wrap_ang(input logic signed [ANG_W-1:0] a);
    if (a > PI_Q32) begin
      return a - TWOPI_Q32;
    end else if (a < -PI_Q32) begin
      return a + TWOPI_Q32;
    end
    return a;
  endfunction

  // optional negate, then round q.32 to q.30
  function automatic logic signed [31:0] rnd2(input logic signed [XY_W-1:0] v,
                                              input logic neg);
    logic signed [XY_W-1:0] t;
    t = neg ? -v : v;
    return 32'((t + XY_W'(2)) >>> 2);
  endfunction

  // degree mode register
  logic cfg_degree_mode_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_degree_mode_r <= 1'b0;
    end else if (cfg_we) begin
      cfg_degree_mode_r <= cfg_wdata;
    end
  end

  assign busy = 1'b0;

  // input register: angles to q.32, azimuth difference at full width
  logic                    s0_vld_r, w1_vld_r, w2_vld_r;
  logic signed [ANG_W-1:0] s0_ang_r [3];
  logic signed [ANG_W-1:0] w1_ang_r [3];
  logic signed [ANG_W-1:0] w2_ang_r [3];
  logic signed [32:0]      dz;

  assign dz = 33'(in_az_b) - 33'(in_az_a);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_vld_r <= 1'b0;
      w1_vld_r <= 1'b0;
      w2_vld_r <= 1'b0;
    end else begin
      s0_vld_r <= start && !busy;
      w1_vld_r <= s0_vld_r;
      w2_vld_r <= w1_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    s0_ang_r[0] <= signed'({{3{in_alt_a[31]}}, in_alt_a, 3'b000});
    s0_ang_r[1] <= signed'({{3{in_alt_b[31]}}, in_alt_b, 3'b000});
    s0_ang_r[2] <= signed'({{2{dz[32]}}, dz, 3'b000});
    for (int l = 0; l < 3; l++) begin
      w1_ang_r[l] <= wrap_ang(s0_ang_r[l]);
      w2_ang_r[l] <= wrap_ang(w1_ang_r[l]);
    end
  end

  // fold into [-pi/2, pi/2], remember to negate sin and cos
  rot_beat_t fold_r;
  rot_beat_t rot_c [CORDIC_STAGES+1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fold_r.vld <= 1'b0;
    end else begin
      fold_r.vld <= w2_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    for (int l = 0; l < 3; l++) begin
      fold_r.lane[l].x <= KINV_Q32;
      fold_r.lane[l].y <= '0;
      if (w2_ang_r[l] > HALFPI_Q32) begin
        fold_r.lane[l].z   <= w2_ang_r[l] - PI_Q32;
        fold_r.lane[l].neg <= 1'b1;
      end else if (w2_ang_r[l] < -HALFPI_Q32) begin
        fold_r.lane[l].z   <= w2_ang_r[l] + PI_Q32;
        fold_r.lane[l].neg <= 1'b1;
      end else begin
        fold_r.lane[l].z   <= w2_ang_r[l];
        fold_r.lane[l].neg <= 1'b0;
      end
    end
  end

  assign rot_c[0] = fold_r;

  // rotation row: lane 0 alt_a, lane 1 alt_b, lane 2 azimuth difference
  for (genvar g = 0; g < CORDIC_STAGES; g++) begin : g_rot
    gcd_rot_cell u_cell (
      .clk   (clk),
      .rst_n (rst_n),
      .step  (6'(g)),
      .d_i   (rot_c[g]),
      .d_o   (rot_c[g+1])
    );
  end

  // sin/cos rounding and the product tree of the law of cosines
  logic               rd_vld_r, m1_vld_r, m2_vld_r, m3_vld_r, m4_vld_r, m5_vld_r;
  logic signed [31:0] sa_r, ca_r, sb_r, cb_r, cd_r;
  logic signed [63:0] pcc_r, pss_r, m2_pss_r, m3_pss_r, pccd_r, csq_r;
  logic signed [31:0] m1_cd_r, m2_cd_r, cc_r, c_r, m5_c_r;
  logic signed [64:0] dot_sum, dot_rnd;
  rot_beat_t          rot_end;

  assign rot_end = rot_c[CORDIC_STAGES];
  assign dot_sum = 65'(m3_pss_r) + 65'(pccd_r);
  assign dot_rnd = (dot_sum + 65'sd536870912) >>> 30;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_vld_r <= 1'b0;
      m1_vld_r <= 1'b0;
      m2_vld_r <= 1'b0;
      m3_vld_r <= 1'b0;
      m4_vld_r <= 1'b0;
      m5_vld_r <= 1'b0;
    end else begin
      rd_vld_r <= rot_end.vld;
      m1_vld_r <= rd_vld_r;
      m2_vld_r <= m1_vld_r;
      m3_vld_r <= m2_vld_r;
      m4_vld_r <= m3_vld_r;
      m5_vld_r <= m4_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    sa_r     <= rnd2(rot_end.lane[0].y, rot_end.lane[0].neg);
    ca_r     <= rnd2(rot_end.lane[0].x, rot_end.lane[0].neg);
    sb_r     <= rnd2(rot_end.lane[1].y, rot_end.lane[1].neg);
    cb_r     <= rnd2(rot_end.lane[1].x, rot_end.lane[1].neg);
    cd_r     <= rnd2(rot_end.lane[2].x, rot_end.lane[2].neg);
    pcc_r    <= 64'(ca_r) * 64'(cb_r);
    pss_r    <= 64'(sa_r) * 64'(sb_r);
    m1_cd_r  <= cd_r;
    cc_r     <= 32'((pcc_r + 64'sd536870912) >>> 30);
    m2_pss_r <= pss_r;
    m2_cd_r  <= m1_cd_r;
    pccd_r   <= 64'(cc_r) * 64'(m2_cd_r);
    m3_pss_r <= m2_pss_r;
    // saturate to +-1 in q.30
    if (dot_rnd > 65'sd1073741824) begin
      c_r <= 32'sd1073741824;
    end else if (dot_rnd < -65'sd1073741824) begin
      c_r <= -32'sd1073741824;
    end else begin
      c_r <= 32'(dot_rnd);
    end
    csq_r  <= 64'(c_r) * 64'(c_r);
    m5_c_r <= c_r;
  end

  // square root row: s = floor(sqrt(2^60 - c^2))
  sq_beat_t sq0_r;
  sq_beat_t sq_c [SQ_STEPS+1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sq0_r.vld <= 1'b0;
    end else begin
      sq0_r.vld <= m5_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    sq0_r.v <= ONE_Q60 - csq_r[SQ_W-1:0];
    sq0_r.r <= '0;
    sq0_r.c <= m5_c_r;
  end

  assign sq_c[0] = sq0_r;

  for (genvar g = 0; g < SQ_STEPS; g++) begin : g_sqrt
    gcd_sqrt_cell u_cell (
      .clk   (clk),
      .rst_n (rst_n),
      .step  (5'(SQ_STEPS - 1 - g)),
      .d_i   (sq_c[g]),
      .d_o   (sq_c[g+1])
    );
  end

  // vectoring start, with a quarter-turn pre-rotation for negative cosines
  vec_beat_t vec0_r;
  vec_beat_t vec_c [CORDIC_STAGES+1];
  sq_beat_t  sq_end;
  logic signed [XY_W-1:0] s4, c4;

  assign sq_end = sq_c[SQ_STEPS];
  assign s4 = signed'({3'b000, sq_end.r[30:0], 2'b00});
  assign c4 = signed'({{2{sq_end.c[31]}}, sq_end.c, 2'b00});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vec0_r.vld <= 1'b0;
    end else begin
      vec0_r.vld <= sq_end.vld;
    end
  end

  always_ff @(posedge clk) begin
    if (sq_end.c < 0) begin
      vec0_r.x <= s4;
      vec0_r.y <= -c4;
      vec0_r.z <= HALFPI_Q32;
    end else begin
      vec0_r.x <= c4;
      vec0_r.y <= s4;
      vec0_r.z <= '0;
    end
  end

  assign vec_c[0] = vec0_r;

  for (genvar g = 0; g < CORDIC_STAGES; g++) begin : g_vec
    gcd_vec_cell u_cell (
      .clk   (clk),
      .rst_n (rst_n),
      .step  (6'(g)),
      .d_i   (vec_c[g]),
      .d_o   (vec_c[g+1])
    );
  end

  // clamp to [0, pi], then radian rounding and degree numerator
  vec_beat_t        vec_end;
  logic             z_vld_r, nm_vld_r, rc_vld_r, qe_vld_r, qp_vld_r;
  logic [33:0]      zc_r;
  logic [41:0]      z180;
  logic [NUM_W-1:0] num_r, rc_num_r, qe_num_r, qp_num_r, qp_r, rem_full;
  logic [63:0]      rc_prod_r;
  logic [31:0]      qe_r, qp_q_r;
  logic [31:0]      nm_rad_r, rc_rad_r, qe_rad_r, qp_rad_r;
  div_beat_t        div0_r;
  div_beat_t        div_c [DIV_STEPS+1];

  assign vec_end  = vec_c[CORDIC_STAGES];
  assign z180     = 42'(zc_r) * 42'd180;
  assign rem_full = qp_num_r - qp_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      z_vld_r    <= 1'b0;
      nm_vld_r   <= 1'b0;
      rc_vld_r   <= 1'b0;
      qe_vld_r   <= 1'b0;
      qp_vld_r   <= 1'b0;
      div0_r.vld <= 1'b0;
    end else begin
      z_vld_r    <= vec_end.vld;
      nm_vld_r   <= z_vld_r;
      rc_vld_r   <= nm_vld_r;
      qe_vld_r   <= rc_vld_r;
      qp_vld_r   <= qe_vld_r;
      div0_r.vld <= qp_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (vec_end.z < 0) begin
      zc_r <= '0;
    end else if (vec_end.z > PI_Q32) begin
      zc_r <= PI_Q32[33:0];
    end else begin
      zc_r <= vec_end.z[33:0];
    end
    // degree numerator with the half-divisor rounding term
    num_r    <= {z180, 20'b0} + PI_Q28_HALF;
    nm_rad_r <= 32'((35'(zc_r) + 35'd2) >> 2);
    // quotient estimate from the top 32 numerator bits and the reciprocal
    rc_prod_r <= 64'(num_r[NUM_W-1:30]) * 64'(DEG_RECIP);
    rc_num_r  <= num_r;
    rc_rad_r  <= nm_rad_r;
    // the estimate falls short of the true quotient by at most four
    qe_r      <= rc_prod_r[62:31];
    qe_num_r  <= rc_num_r;
    qe_rad_r  <= rc_rad_r;
    qp_r      <= NUM_W'(qe_r) * NUM_W'(PI_Q28);
    qp_q_r    <= qe_r;
    qp_num_r  <= qe_num_r;
    qp_rad_r  <= qe_rad_r;
    // remainder is below five times pi_q28, so 32 bits hold it
    div0_r.rem <= rem_full[DIV_W-1:0];
    div0_r.q   <= qp_q_r;
    div0_r.rad <= qp_rad_r;
  end

  assign div_c[0] = div0_r;

  // correction row: each cell takes off pi_q28 once while the remainder allows
  for (genvar g = 0; g < DIV_STEPS; g++) begin : g_div
    gcd_div_cell u_cell (
      .clk   (clk),
      .rst_n (rst_n),
      .d_i   (div_c[g]),
      .d_o   (div_c[g+1])
    );
  end

  // output register, mode bit kept alongside the beat
  div_beat_t   div_end;
  logic        out_valid_r, out_deg_r;
  logic [31:0] out_distance_r;

  assign div_end = div_c[DIV_STEPS];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= div_end.vld;
    end
  end

  always_ff @(posedge clk) begin
    out_deg_r      <= cfg_degree_mode_r;
    out_distance_r <= cfg_degree_mode_r ? div_end.q : div_end.rad;
  end

  assign out_valid    = out_valid_r;
  assign out_distance = out_distance_r;

  // checks
  `GCD_ASSERT_PAST(a_latency, out_valid, (start && !busy), LAT, "result without matching start")
  `GCD_ASSERT(a_rad_range, (out_valid && !out_deg_r) |-> (out_distance <= 32'hC90FDAA2), "radians beyond pi")
  `GCD_ASSERT(a_deg_range, (out_valid && out_deg_r) |-> (out_distance <= 32'hB4000000), "degrees beyond 180")
  `GCD_ASSERT(a_sqrt_range, sq_end.vld |-> (sq_end.r <= SQ_W'(1) << 30), "square root beyond one")

endmodule
`default_nettype wire
